/* sv/iee_pkg.sv */
`default_nettype none
package iee_pkg;

    localparam int STACK_DEPTH     = 32;
    localparam int ADDR_W          = $clog2(STACK_DEPTH);
    localparam int TOP_W           = ADDR_W + 1;
    localparam int FRAC_BITS       = 32;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int DIV_STEPS       = 128;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

    localparam logic [7:0] CH_MUL  = 8'h78;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [63:0] VMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VMIN_MAG = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_BAD  = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LIT,
        S_LITDIV,
        S_LITPUSH,
        S_OPCHK,
        S_OPCMP,
        S_OPPUSH,
        S_RA,
        S_RB,
        S_RB2,
        S_RA2,
        S_EXEC,
        S_MUL,
        S_MULFIN,
        S_DIV,
        S_RPUSH,
        S_END,
        S_ENDRD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot_lo;
        logic        quot_hi_nz;
    } div_rsp_t;

    typedef struct packed {
        logic        ovf;
        logic [63:0] val;
    } sat_t;

    function automatic logic [63:0] pow10(input logic [3:0] n);
        logic [63:0] r;
        r = 64'd1;
        case (n)
            4'd1:    r = 64'd10;
            4'd2:    r = 64'd100;
            4'd3:    r = 64'd1000;
            4'd4:    r = 64'd10000;
            4'd5:    r = 64'd100000;
            4'd6:    r = 64'd1000000;
            4'd7:    r = 64'd10000000;
            4'd8:    r = 64'd100000000;
            4'd9:    r = 64'd1000000000;
            default: r = 64'd1;
        endcase
        return r;
    endfunction

    function automatic sat_t signed_sat(input logic [63:0] m, input logic neg);
        sat_t r;
        r.ovf = 1'b0;
        r.val = m;
        if (neg) begin
            if (m > VMIN_MAG) begin
                r.ovf = 1'b1;
                r.val = VMIN_MAG;
            end
            else begin
                r.val = 64'd0 - m;
            end
        end
        else if (m > VMAX) begin
            r.ovf = 1'b1;
            r.val = VMAX;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [1:0] prec(input logic [1:0] op);
        return (op >= OP_MUL) ? 2'd2 : 2'd1;
    endfunction

    function automatic logic [1:0] flag(input logic [1:0] cur, input logic [1:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

endpackage
`default_nettype wire

/* sv/infix_expression_evaluator.sv */
`default_nettype none
// Character transfer: digits and '.' are taken in S_IDLE; other characters pass through S_LIT
// and the operator states, plus a reduction (S_RA to S_RPUSH) per popped operator; s_tready is low meanwhile.
// A literal with a fraction runs the shared 1-bit/cycle divider (128 steps + done).
// End of expression runs its reductions and S_END/S_ENDRD; result held in an output register,
// a second result waits in S_OUT until m_tready.
// rst_n is asynchronous, active low; clears control state and empties both stacks.
module infix_expression_evaluator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // end_of_expr
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [63:0] result_value, [65:64] status, zero pad
);

    localparam int TW = iee_pkg::TOP_W;
    localparam int AW = iee_pkg::ADDR_W;

    iee_pkg::state_t   state_reg, state_next;
    logic [TW-1:0]     vtop_reg, vtop_next;
    logic [TW-1:0]     otop_reg, otop_next;
    logic [31:0]       int_reg, int_next;
    logic [31:0]       frac_reg, frac_next;
    logic [3:0]        fdig_reg, fdig_next;
    logic              act_reg, act_next;
    logic              dot_reg, dot_next;
    logic              stop_reg, stop_next;
    logic [1:0]        stat_reg, stat_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    logic              ret_end_reg, ret_end_next;
    logic              rdok_reg, rdok_next;
    logic [1:0]        op_reg, op_next;
    logic [63:0]       a_reg, a_next;
    logic [63:0]       b_reg, b_next;
    logic [63:0]       res_reg, res_next;
    logic [2:0]        mcnt_reg, mcnt_next;
    logic [63:0]       pp_reg, pp_next;
    logic [1:0]        psh_reg, psh_next;
    logic [127:0]      prod_reg, prod_next;
    logic              ov_reg, ov_next;
    logic [63:0]       oval_reg, oval_next;
    logic [1:0]        ostat_reg, ostat_next;

    logic [63:0]       vs_mem [iee_pkg::STACK_DEPTH];
    logic [1:0]        os_mem [iee_pkg::STACK_DEPTH];
    logic [63:0]       vs_rd_reg;
    logic [1:0]        os_rd_reg;
    logic              vs_we, os_we;
    logic [AW-1:0]     vs_waddr, os_waddr, vs_raddr, os_raddr;
    logic [63:0]       vs_wdata;
    logic [1:0]        os_wdata;

    iee_pkg::div_req_t div_req;
    iee_pkg::div_rsp_t div_rsp;

    logic              accept;
    logic              in_digit, in_dot, is_op, vfull, ofull;
    logic [1:0]        in_op;
    logic [3:0]        dval;
    logic [35:0]       int_x10;
    logic [TW-1:0]     vtop_m1, otop_m1;
    logic [63:0]       mag_a, mag_b;
    logic              res_neg;
    iee_pkg::sat_t     mul_sat, div_sat;

    iee_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == iee_pkg::S_IDLE);
    assign in_digit = (s_tdata >= iee_pkg::CH_ZERO) && (s_tdata <= iee_pkg::CH_NINE);
    assign in_dot   = (s_tdata == iee_pkg::CH_DOT);
    assign dval     = 4'(s_tdata - iee_pkg::CH_ZERO);
    assign int_x10  = {1'b0, int_reg, 3'b0} + {3'b0, int_reg, 1'b0} + {32'd0, dval};
    assign vfull    = (vtop_reg >= TW'(iee_pkg::STACK_DEPTH));
    assign ofull    = (otop_reg >= TW'(iee_pkg::STACK_DEPTH));
    assign vtop_m1  = vtop_reg - 1'b1;
    assign otop_m1  = otop_reg - 1'b1;
    assign vs_raddr = vtop_m1[AW-1:0];
    assign os_raddr = otop_m1[AW-1:0];
    assign vs_waddr = vtop_reg[AW-1:0];
    assign os_waddr = otop_reg[AW-1:0];
    assign mag_a    = iee_pkg::mag(a_reg);
    assign mag_b    = iee_pkg::mag(b_reg);
    assign res_neg  = (a_reg[63] != b_reg[63]);
    assign mul_sat  = iee_pkg::signed_sat(prod_reg[95:32], res_neg);
    assign div_sat  = iee_pkg::signed_sat(div_rsp.quot_lo, res_neg);

    always_comb
    begin
        is_op = 1'b1;
        in_op = iee_pkg::OP_ADD;
        case (char_reg)
            iee_pkg::CH_ADD: in_op = iee_pkg::OP_ADD;
            iee_pkg::CH_SUB: in_op = iee_pkg::OP_SUB;
            iee_pkg::CH_MUL: in_op = iee_pkg::OP_MUL;
            iee_pkg::CH_DIV: in_op = iee_pkg::OP_DIV;
            default:         is_op = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iee_pkg::S_IDLE:
                if (accept && (!(in_digit || in_dot) || s_tlast))
                    state_next = iee_pkg::S_LIT;
            iee_pkg::S_LIT:
                if (!act_reg)
                    state_next = is_op ? iee_pkg::S_OPCHK
                               : (last_reg ? iee_pkg::S_END : iee_pkg::S_IDLE);
                else if (!int_reg[31] && fdig_reg != 4'd0)
                    state_next = iee_pkg::S_LITDIV;
                else
                    state_next = iee_pkg::S_LITPUSH;
            iee_pkg::S_LITDIV:
                if (div_rsp.done)
                    state_next = iee_pkg::S_LITPUSH;
            iee_pkg::S_LITPUSH:
                state_next = is_op ? iee_pkg::S_OPCHK
                           : (last_reg ? iee_pkg::S_END : iee_pkg::S_IDLE);
            iee_pkg::S_OPCHK:
                state_next = (otop_reg != '0) ? iee_pkg::S_OPCMP : iee_pkg::S_OPPUSH;
            iee_pkg::S_OPCMP:
                state_next = (iee_pkg::prec(os_rd_reg) >= iee_pkg::prec(in_op))
                           ? iee_pkg::S_RA : iee_pkg::S_OPPUSH;
            iee_pkg::S_OPPUSH:
                state_next = last_reg ? iee_pkg::S_END : iee_pkg::S_IDLE;
            iee_pkg::S_RA:    state_next = iee_pkg::S_RB;
            iee_pkg::S_RB:    state_next = iee_pkg::S_RB2;
            iee_pkg::S_RB2:   state_next = iee_pkg::S_RA2;
            iee_pkg::S_RA2:   state_next = iee_pkg::S_EXEC;
            iee_pkg::S_EXEC:
                case (op_reg)
                    iee_pkg::OP_MUL: state_next = iee_pkg::S_MUL;
                    iee_pkg::OP_DIV:
                        state_next = (b_reg == 64'd0) ? iee_pkg::S_RPUSH : iee_pkg::S_DIV;
                    default:         state_next = iee_pkg::S_RPUSH;
                endcase
            iee_pkg::S_MUL:
                if (mcnt_reg == 3'd4)
                    state_next = iee_pkg::S_MULFIN;
            iee_pkg::S_MULFIN: state_next = iee_pkg::S_RPUSH;
            iee_pkg::S_DIV:
                if (div_rsp.done)
                    state_next = iee_pkg::S_RPUSH;
            iee_pkg::S_RPUSH:
                state_next = ret_end_reg ? iee_pkg::S_END : iee_pkg::S_OPCHK;
            iee_pkg::S_END:
                if (otop_reg != '0)
                    state_next = iee_pkg::S_RA;
                else if (vtop_reg == '0)
                    state_next = iee_pkg::S_OUT;
                else
                    state_next = iee_pkg::S_ENDRD;
            iee_pkg::S_ENDRD: state_next = iee_pkg::S_OUT;
            iee_pkg::S_OUT:
                if (!ov_reg || m_tready)
                    state_next = iee_pkg::S_IDLE;
            default: state_next = iee_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        vtop_next    = vtop_reg;
        otop_next    = otop_reg;
        int_next     = int_reg;
        frac_next    = frac_reg;
        fdig_next    = fdig_reg;
        act_next     = act_reg;
        dot_next     = dot_reg;
        stop_next    = stop_reg;
        stat_next    = stat_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        ret_end_next = ret_end_reg;
        rdok_next    = rdok_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        res_next     = res_reg;
        mcnt_next    = mcnt_reg;
        pp_next      = pp_reg;
        psh_next     = psh_reg;
        prod_next    = prod_reg;
        ov_next      = ov_reg;
        oval_next    = oval_reg;
        ostat_next   = ostat_reg;
        vs_we        = 1'b0;
        vs_wdata     = res_reg;
        os_we        = 1'b0;
        os_wdata     = in_op;
        div_req      = '0;
        if (ov_reg && m_tready)
            ov_next = 1'b0;
        case (state_reg)
            iee_pkg::S_IDLE:
                if (accept)
                begin
                    char_next = s_tdata;
                    last_next = s_tlast;
                    if (in_digit || in_dot)
                    begin
                        act_next = 1'b1;
                        if (in_dot)
                        begin
                            if (dot_reg)
                                stop_next = 1'b1;
                            else
                                dot_next = 1'b1;
                        end
                        else if (!stop_reg)
                        begin
                            if (!dot_reg)
                            begin
                                if (int_x10[35:32] != 4'd0)
                                begin
                                    stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_SAT);
                                    int_next  = 32'hFFFF_FFFF;
                                end
                                else
                                    int_next = int_x10[31:0];
                            end
                            else if (fdig_reg < 4'(iee_pkg::MAX_FRAC_DIGITS))
                            begin
                                frac_next = {frac_reg[28:0], 3'b0} + {frac_reg[30:0], 1'b0}
                                          + {28'd0, dval};
                                fdig_next = fdig_reg + 1'b1;
                            end
                        end
                    end
                end
            iee_pkg::S_LIT:
                if (act_reg)
                begin
                    if (int_reg[31])
                    begin
                        stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_SAT);
                        res_next  = iee_pkg::VMAX;
                    end
                    else if (fdig_reg != 4'd0)
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = {32'd0, frac_reg};
                        div_req.den   = iee_pkg::pow10(fdig_reg);
                    end
                    else
                        res_next = {int_reg, 32'd0};
                end
            iee_pkg::S_LITDIV:
                if (div_rsp.done)
                    res_next = {int_reg, 32'd0} + div_rsp.quot_lo;
            iee_pkg::S_LITPUSH:
            begin
                if (vfull)
                    stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_BAD);
                else
                begin
                    vs_we     = 1'b1;
                    vtop_next = vtop_reg + 1'b1;
                end
                int_next  = '0;
                frac_next = '0;
                fdig_next = '0;
                act_next  = 1'b0;
                dot_next  = 1'b0;
                stop_next = 1'b0;
            end
            iee_pkg::S_OPCMP:
                ret_end_next = 1'b0;
            iee_pkg::S_OPPUSH:
                if (ofull)
                    stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_BAD);
                else
                begin
                    os_we     = 1'b1;
                    otop_next = otop_reg + 1'b1;
                end
            iee_pkg::S_RA:
                otop_next = otop_m1;
            iee_pkg::S_RB:
            begin
                op_next = os_rd_reg;
                if (vtop_reg != '0)
                begin
                    vtop_next = vtop_m1;
                    rdok_next = 1'b1;
                end
                else
                begin
                    rdok_next = 1'b0;
                    stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_BAD);
                end
            end
            iee_pkg::S_RB2:
            begin
                b_next = rdok_reg ? vs_rd_reg : 64'd0;
                if (vtop_reg != '0)
                begin
                    vtop_next = vtop_m1;
                    rdok_next = 1'b1;
                end
                else
                begin
                    rdok_next = 1'b0;
                    stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_BAD);
                end
            end
            iee_pkg::S_RA2:
                a_next = rdok_reg ? vs_rd_reg : 64'd0;
            iee_pkg::S_EXEC:
            begin
                case (op_reg)
                    iee_pkg::OP_ADD:
                    begin
                        res_next = a_reg + b_reg;
                        if (a_reg[63] == b_reg[63] && res_next[63] != a_reg[63])
                        begin
                            stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_SAT);
                            res_next  = a_reg[63] ? iee_pkg::VMIN_MAG : iee_pkg::VMAX;
                        end
                    end
                    iee_pkg::OP_SUB:
                    begin
                        res_next = a_reg - b_reg;
                        if (a_reg[63] != b_reg[63] && res_next[63] != a_reg[63])
                        begin
                            stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_SAT);
                            res_next  = a_reg[63] ? iee_pkg::VMIN_MAG : iee_pkg::VMAX;
                        end
                    end
                    iee_pkg::OP_MUL:
                    begin
                        mcnt_next = '0;
                        prod_next = '0;
                    end
                    default:
                        if (b_reg == 64'd0)
                        begin
                            stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_DIV0);
                            res_next  = 64'd0;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            div_req.num   = mag_a;
                            div_req.den   = mag_b;
                        end
                endcase
            end
            iee_pkg::S_MUL:
            begin
                if (mcnt_reg != 3'd0)
                    prod_next = prod_reg + ({64'd0, pp_reg} << (7'd32 * psh_reg));
                case (mcnt_reg)
                    3'd0:
                    begin
                        pp_next  = mag_a[31:0] * mag_b[31:0];
                        psh_next = 2'd0;
                    end
                    3'd1:
                    begin
                        pp_next  = mag_a[31:0] * mag_b[63:32];
                        psh_next = 2'd1;
                    end
                    3'd2:
                    begin
                        pp_next  = mag_a[63:32] * mag_b[31:0];
                        psh_next = 2'd1;
                    end
                    3'd3:
                    begin
                        pp_next  = mag_a[63:32] * mag_b[63:32];
                        psh_next = 2'd2;
                    end
                    default: pp_next = pp_reg;
                endcase
                mcnt_next = mcnt_reg + 1'b1;
            end
            iee_pkg::S_MULFIN:
                if (prod_reg[127:96] != 32'd0)
                begin
                    stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_SAT);
                    res_next  = res_neg ? iee_pkg::VMIN_MAG : iee_pkg::VMAX;
                end
                else
                begin
                    res_next = mul_sat.val;
                    if (mul_sat.ovf)
                        stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_SAT);
                end
            iee_pkg::S_DIV:
                if (div_rsp.done)
                begin
                    if (div_rsp.quot_hi_nz)
                    begin
                        stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_SAT);
                        res_next  = res_neg ? iee_pkg::VMIN_MAG : iee_pkg::VMAX;
                    end
                    else
                    begin
                        res_next = div_sat.val;
                        if (div_sat.ovf)
                            stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_SAT);
                    end
                end
            iee_pkg::S_RPUSH:
                if (vfull)
                    stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_BAD);
                else
                begin
                    vs_we     = 1'b1;
                    vtop_next = vtop_reg + 1'b1;
                end
            iee_pkg::S_END:
            begin
                ret_end_next = 1'b1;
                if (otop_reg == '0 && vtop_reg == '0)
                begin
                    stat_next = iee_pkg::flag(stat_reg, iee_pkg::ST_BAD);
                    res_next  = 64'd0;
                end
            end
            iee_pkg::S_ENDRD:
                res_next = vs_rd_reg;
            iee_pkg::S_OUT:
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    oval_next  = res_reg;
                    ostat_next = stat_reg;
                    vtop_next  = '0;
                    otop_next  = '0;
                    stat_next  = iee_pkg::ST_OK;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= iee_pkg::S_IDLE;
            vtop_reg    <= '0;
            otop_reg    <= '0;
            int_reg     <= '0;
            frac_reg    <= '0;
            fdig_reg    <= '0;
            act_reg     <= 1'b0;
            dot_reg     <= 1'b0;
            stop_reg    <= 1'b0;
            stat_reg    <= iee_pkg::ST_OK;
            ret_end_reg <= 1'b0;
            rdok_reg    <= 1'b0;
            mcnt_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vtop_reg    <= vtop_next;
            otop_reg    <= otop_next;
            int_reg     <= int_next;
            frac_reg    <= frac_next;
            fdig_reg    <= fdig_next;
            act_reg     <= act_next;
            dot_reg     <= dot_next;
            stop_reg    <= stop_next;
            stat_reg    <= stat_next;
            ret_end_reg <= ret_end_next;
            rdok_reg    <= rdok_next;
            mcnt_reg    <= mcnt_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        last_reg  <= last_next;
        op_reg    <= op_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        res_reg   <= res_next;
        pp_reg    <= pp_next;
        psh_reg   <= psh_next;
        prod_reg  <= prod_next;
        oval_reg  <= oval_next;
        ostat_reg <= ostat_next;
    end

    always_ff @(posedge clk)
    begin
        if (vs_we)
            vs_mem[vs_waddr] <= vs_wdata;
        vs_rd_reg <= vs_mem[vs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (os_we)
            os_mem[os_waddr] <= os_wdata;
        os_rd_reg <= os_mem[os_raddr];
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'd0, ostat_reg, oval_reg};

`ifndef SYNTHESIS
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (stat_reg != iee_pkg::ST_OK && state_reg != iee_pkg::S_OUT)
        |=> stat_reg == $past(stat_reg)) else $error("status not sticky");
    a_vtop: assert property (@(posedge clk) disable iff (!rst_n)
        vtop_reg <= TW'(iee_pkg::STACK_DEPTH)) else $error("value stack past depth");
    a_otop: assert property (@(posedge clk) disable iff (!rst_n)
        otop_reg <= TW'(iee_pkg::STACK_DEPTH)) else $error("op stack past depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result changed");
`endif

endmodule
`default_nettype wire

/* sv/iee_div.sv */
`default_nettype none
module iee_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire iee_pkg::div_req_t  req,
    output iee_pkg::div_rsp_t       rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [iee_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [127:0]                   num_reg, num_next;
    logic [127:0]                   quot_reg, quot_next;
    logic [63:0]                    rem_reg, rem_next;
    logic [63:0]                    den_reg, den_next;
    logic [64:0]                    rem_sh;
    logic [64:0]                    rem_sub;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg, num_reg[127]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = {32'd0, req.num, 32'd0};
            quot_next = '0;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[126:0], 1'b0};
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next  = rem_sub[63:0];
                quot_next = {quot_reg[126:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[63:0];
                quot_next = {quot_reg[126:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == iee_pkg::DIV_CNT_W'(iee_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.busy       = busy_reg;
    assign rsp.done       = done_reg;
    assign rsp.quot_lo    = quot_reg[63:0];
    assign rsp.quot_hi_nz = (quot_reg[127:64] != 64'd0);

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg) else $error("divide restarted while busy");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> req.den != 64'd0) else $error("divide by zero started");
`endif

endmodule
`default_nettype wire

/* tb/infix_expression_evaluator_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module infix_expression_evaluator_tb;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_EXPRS   = 55;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  status;
    } eval_result_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       has_exp;
        logic [63:0] exp_value;
        logic [1:0]  exp_status;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    eval_result_t expected_results[$];
    int  errors;
    int  idle_cycles;
    bit  quiet_mode;
    bit  stim_done;

    logic [63:0] vstk[iee_pkg::STACK_DEPTH];
    logic [1:0]  ostk[iee_pkg::STACK_DEPTH];
    int          vcnt;
    int          ocnt;
    logic [31:0] int_acc;
    logic [31:0] frac_acc;
    int          frac_cnt;
    bit          in_lit;
    bit          dot_seen;
    bit          lit_stop;
    logic [1:0]  sticky;

    infix_expression_evaluator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void calc_clear();
        vcnt = 0;
        ocnt = 0;
        int_acc = '0;
        frac_acc = '0;
        frac_cnt = 0;
        in_lit = 0;
        dot_seen = 0;
        lit_stop = 0;
        sticky = iee_pkg::ST_OK;
    endfunction

    function automatic void raise(input logic [1:0] code);
        if (sticky == iee_pkg::ST_OK)
            sticky = code;
    endfunction

    function automatic void vpush(input logic [63:0] v);
        if (vcnt >= iee_pkg::STACK_DEPTH)
            raise(iee_pkg::ST_BAD);
        else
        begin
            vstk[vcnt] = v;
            vcnt++;
        end
    endfunction

    function automatic logic [63:0] vpop();
        if (vcnt == 0)
        begin
            raise(iee_pkg::ST_BAD);
            return '0;
        end
        vcnt--;
        return vstk[vcnt];
    endfunction

    function automatic logic [63:0] absval(input logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] apply_sign(input logic [63:0] m, input bit neg);
        if (neg)
        begin
            if (m > 64'h8000_0000_0000_0000)
            begin
                raise(iee_pkg::ST_SAT);
                return 64'h8000_0000_0000_0000;
            end
            return -m;
        end
        if (m > 64'h7FFF_FFFF_FFFF_FFFF)
        begin
            raise(iee_pkg::ST_SAT);
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return m;
    endfunction

    function automatic logic [63:0] arith(input logic [1:0] op, input logic [63:0] a,
                                          input logic [63:0] b);
        logic [63:0]  s;
        logic [127:0] p;
        logic [127:0] q;
        bit           neg;
        neg = a[63] ^ b[63];
        case (op)
            iee_pkg::OP_ADD, iee_pkg::OP_SUB:
            begin
                s = (op == iee_pkg::OP_ADD) ? a + b : a - b;
                if (((op == iee_pkg::OP_ADD) ? (a[63] == b[63]) : (a[63] != b[63]))
                    && s[63] != a[63])
                begin
                    raise(iee_pkg::ST_SAT);
                    return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                end
                return s;
            end
            iee_pkg::OP_MUL:
            begin
                p = {64'd0, absval(a)} * {64'd0, absval(b)};
                if (p[127:96] != 0)
                begin
                    raise(iee_pkg::ST_SAT);
                    return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                end
                return apply_sign(p[95:32], neg);
            end
            default:
            begin
                if (b == 0)
                begin
                    raise(iee_pkg::ST_DIV0);
                    return '0;
                end
                q = {32'd0, absval(a), 32'd0} / {64'd0, absval(b)};
                if (q[127:64] != 0)
                begin
                    raise(iee_pkg::ST_SAT);
                    return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                end
                return apply_sign(q[63:0], neg);
            end
        endcase
    endfunction

    function automatic void reduce_top();
        logic [1:0]  op;
        logic [63:0] a;
        logic [63:0] b;
        if (ocnt == 0)
            return;
        ocnt--;
        op = ostk[ocnt];
        b = vpop();
        a = vpop();
        vpush(arith(op, a, b));
    endfunction

    function automatic logic [63:0] pow10_u(input int n);
        logic [63:0] r;
        r = 1;
        repeat (n) r = r * 10;
        return r;
    endfunction

    function automatic void close_literal();
        logic [63:0] f;
        if (!in_lit)
            return;
        if (int_acc > 32'h7FFF_FFFF)
        begin
            raise(iee_pkg::ST_SAT);
            vpush(64'h7FFF_FFFF_FFFF_FFFF);
        end
        else
        begin
            f = '0;
            if (frac_cnt > 0)
                f = {frac_acc, 32'd0} / pow10_u(frac_cnt);
            vpush({int_acc, 32'd0} + f);
        end
        int_acc = '0;
        frac_acc = '0;
        frac_cnt = 0;
        in_lit = 0;
        dot_seen = 0;
        lit_stop = 0;
    endfunction

    function automatic int level(input logic [1:0] op);
        return (op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV) ? 2 : 1;
    endfunction

    // returns 1 when the character closes an expression
    function automatic bit calc_char(input logic [7:0] c, input logic last,
                                     output eval_result_t r);
        logic [1:0] op;
        bit         is_op;
        logic [31:0] d;
        is_op = 0;
        op = iee_pkg::OP_ADD;
        if ((c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) || c == iee_pkg::CH_DOT)
        begin
            in_lit = 1;
            if (c == iee_pkg::CH_DOT)
            begin
                if (dot_seen)
                    lit_stop = 1;
                else
                    dot_seen = 1;
            end
            else if (!lit_stop)
            begin
                d = {24'd0, c - iee_pkg::CH_ZERO};
                if (!dot_seen)
                begin
                    if (int_acc > (32'hFFFF_FFFF - d) / 10)
                    begin
                        raise(iee_pkg::ST_SAT);
                        int_acc = 32'hFFFF_FFFF;
                    end
                    else
                        int_acc = int_acc * 10 + d;
                end
                else if (frac_cnt < iee_pkg::MAX_FRAC_DIGITS)
                begin
                    frac_acc = frac_acc * 10 + d;
                    frac_cnt++;
                end
            end
        end
        else
        begin
            close_literal();
            case (c)
                iee_pkg::CH_ADD: begin op = iee_pkg::OP_ADD; is_op = 1; end
                iee_pkg::CH_SUB: begin op = iee_pkg::OP_SUB; is_op = 1; end
                iee_pkg::CH_MUL: begin op = iee_pkg::OP_MUL; is_op = 1; end
                iee_pkg::CH_DIV: begin op = iee_pkg::OP_DIV; is_op = 1; end
                default: ;
            endcase
            if (is_op)
            begin
                while (ocnt > 0 && level(ostk[ocnt - 1]) >= level(op))
                    reduce_top();
                if (ocnt >= iee_pkg::STACK_DEPTH)
                    raise(iee_pkg::ST_BAD);
                else
                begin
                    ostk[ocnt] = op;
                    ocnt++;
                end
            end
        end
        if (!last)
            return 0;
        close_literal();
        while (ocnt > 0)
            reduce_top();
        if (vcnt == 0)
        begin
            raise(iee_pkg::ST_BAD);
            r.value = '0;
        end
        else
            r.value = vstk[vcnt - 1];
        r.status = sticky;
        calc_clear();
        return 1;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        eval_result_t r;
        if (!quiet_mode)
            while ($urandom_range(99) < 32)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (calc_char(c, last, r))
            expected_results.push_back(r);
        @(negedge clk);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(iee_pkg::CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(3))
            0: return iee_pkg::CH_ADD;
            1: return iee_pkg::CH_SUB;
            2: return iee_pkg::CH_MUL;
            default: return iee_pkg::CH_DIV;
        endcase
    endfunction

    // digits separated by spaces to overflow the value stack
    function automatic logic [7:0] CH_ONE_OR(input int i);
        return (i % 2 == 0) ? 8'h31 : 8'h20;
    endfunction

    task automatic send_random_expr();
        int nterms;
        int ndig;
        nterms = ($urandom_range(19) == 0) ? $urandom_range(34, 40) : $urandom_range(1, 5);
        for (int t = 0; t < nterms; t++)
        begin
            if (t > 0)
                send_char(rand_op(), 1'b0);
            ndig = $urandom_range(1, ($urandom_range(9) == 0) ? 12 : 3);
            for (int k = 0; k < ndig; k++)
                send_char(rand_digit(), 1'b0);
            if ($urandom_range(3) == 0)
            begin
                send_char(iee_pkg::CH_DOT, 1'b0);
                ndig = $urandom_range(0, ($urandom_range(5) == 0) ? 11 : 2);
                for (int k = 0; k < ndig; k++)
                    send_char(($urandom_range(15) == 0) ? iee_pkg::CH_DOT : rand_digit(), 1'b0);
            end
            if ($urandom_range(15) == 0)
                send_char(8'($urandom_range(255)), 1'b0);
        end
        if ($urandom_range(3) == 0)
            send_char(8'($urandom_range(255)), 1'b1);
        else
            send_char(rand_digit(), 1'b1);
    endtask

    initial
    begin
        dir_row_t rows[$];
        string    exprs[$];
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        quiet_mode = 0;
        stim_done = 0;
        errors = 0;
        calc_clear();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        rows.push_back('{8'h00, 1'b1, 1'b1, 64'd0, iee_pkg::ST_BAD});
        rows.push_back('{iee_pkg::CH_NINE, 1'b1, 1'b1, 64'h9_0000_0000, iee_pkg::ST_OK});
        rows.push_back('{iee_pkg::CH_ZERO, 1'b0, 1'b0, 64'd0, iee_pkg::ST_OK});
        rows.push_back('{iee_pkg::CH_DIV, 1'b0, 1'b0, 64'd0, iee_pkg::ST_OK});
        rows.push_back('{iee_pkg::CH_ZERO, 1'b1, 1'b1, 64'd0, iee_pkg::ST_DIV0});
        rows.push_back('{iee_pkg::CH_SUB, 1'b0, 1'b0, 64'd0, iee_pkg::ST_OK});
        rows.push_back('{8'd53, 1'b1, 1'b1, 64'hFFFF_FFFB_0000_0000, iee_pkg::ST_BAD});
        rows.push_back('{iee_pkg::CH_DOT, 1'b1, 1'b1, 64'd0, iee_pkg::ST_OK});
        rows.push_back('{8'hFF, 1'b0, 1'b0, 64'd0, iee_pkg::ST_OK});
        rows.push_back('{iee_pkg::CH_MUL, 1'b1, 1'b1, 64'd0, iee_pkg::ST_BAD});
        foreach (rows[i])
        begin
            eval_result_t r;
            send_char(rows[i].ch, rows[i].last);
            if (rows[i].has_exp)
            begin
                r = expected_results[$];
                if (r.value !== rows[i].exp_value)
                begin
                    $error("table row %0d: result_value exp %h got %h",
                           i, rows[i].exp_value, r.value);
                    errors++;
                end
                if (r.status !== rows[i].exp_status)
                begin
                    $error("table row %0d: status exp %0d got %0d",
                           i, rows[i].exp_status, r.status);
                    errors++;
                end
            end
        end

        exprs = '{"1+2x3-4/2", "2.5x4.25", "12.3.45+0.123456789123", "99999999999+1",
                  "2147483647x2147483647", "0-2147483647-2147483647-2147483647",
                  "1/3", "7/0x2+1", "1..5+.", "5x-3", "8 / 2 + 1"};
        foreach (exprs[i])
            send_string(exprs[i]);
        for (int i = 0; i < 70; i++)
            send_char(CH_ONE_OR(i), 1'b0);
        send_char(iee_pkg::CH_ADD, 1'b1);

        for (int n = 0; n < RANDOM_EXPRS; n++)
        begin
            quiet_mode = (n >= 20 && n < 32);
            send_random_expr();
        end
        quiet_mode = 0;
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        eval_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with none expected: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[63:0] !== want.value)
                begin
                    $error("result_value exp %h got %h", want.value, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[65:64] !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, m_tdata[65:64]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (stim_done && expected_results.size() == 0)
            begin
                repeat (200) @(posedge clk);
                if (errors == 0 && expected_results.size() == 0)
                    $display("[ OK ] regression clean");
                else
                    $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
